@@ rtl/cddoy_pkg.sv @@
package cddoy_pkg;

   localparam int YEAR_W  = 16;
   localparam int MONTH_W = 4;
   localparam int MDAY_W  = 6;
   localparam int YDAY_W  = 9;
   localparam int MDO_W   = 5;

   localparam logic [MONTH_W-1:0] MONTHS      = 4'd12;
   localparam logic [YDAY_W-1:0]  DAYS_COMMON = 9'd365;
   localparam logic [YDAY_W-1:0]  DAYS_LEAP   = 9'd366;
   localparam logic [MDO_W-1:0]   FEB_COMMON  = 5'd28;
   localparam logic [MDO_W-1:0]   FEB_LEAP    = 5'd29;

   // y is a multiple of 25 iff (y * inverse of 25 mod 2^16) <= floor((2^16-1)/25)
   localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
   localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

   typedef logic [2:0] pc_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_INIT,
      OP_CHK_FWD,
      OP_ADD,
      OP_CHK_INV,
      OP_SUB,
      OP_DONE
   } op_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_INV,
      COND_FWD_MORE,
      COND_INV_MORE,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      pc_type   t_pc;
      pc_type   f_pc;
   } ucode_word_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic func_inv;
      logic fwd_more;
      logic inv_more;
      logic out_free;
   } status_type;

   localparam pc_type PC_INIT    = 3'd0;
   localparam pc_type PC_CHK_FWD = 3'd1;
   localparam pc_type PC_ADD     = 3'd2;
   localparam pc_type PC_CHK_INV = 3'd3;
   localparam pc_type PC_SUB     = 3'd4;
   localparam pc_type PC_DONE    = 3'd5;

   function automatic ucode_word_type ucode_rom(input pc_type pc);
      ucode_word_type w;
      case (pc)
         PC_INIT:    w = '{OP_INIT,    COND_INV,      PC_CHK_INV, PC_CHK_FWD};
         PC_CHK_FWD: w = '{OP_CHK_FWD, COND_ALWAYS,   PC_ADD,     PC_ADD};
         PC_ADD:     w = '{OP_ADD,     COND_FWD_MORE, PC_ADD,     PC_DONE};
         PC_CHK_INV: w = '{OP_CHK_INV, COND_ALWAYS,   PC_SUB,     PC_SUB};
         PC_SUB:     w = '{OP_SUB,     COND_INV_MORE, PC_SUB,     PC_DONE};
         PC_DONE:    w = '{OP_DONE,    COND_OUT_FREE, PC_INIT,    PC_DONE};
         default:    w = '{OP_NOP,     COND_ALWAYS,   PC_INIT,    PC_INIT};
      endcase
      return w;
   endfunction

   function automatic logic [MDO_W-1:0] month_len(input logic leap,
                                                  input logic [MONTH_W-1:0] m);
      logic [MDO_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:    len = leap ? FEB_LEAP : FEB_COMMON;
         default: len = '0;
      endcase
      return len;
   endfunction

   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [YEAR_W-1:0] prod;
      logic div4;
      logic div16;
      logic div25;
      prod  = y * INV25;
      div4  = (y[1:0] == 2'd0);
      div16 = (y[3:0] == 4'd0);
      div25 = (prod <= DIV25_MAX);
      return (div4 && !div25) || (div16 && div25);
   endfunction

endpackage

@@ rtl/calendar_date_day_of_year_convert.sv @@
// Gregorian date <-> day-of-year converter run by a small microcode sequencer.
// req_func 0 turns year/month/day into the day of year; req_func 1 turns year and
// day of year into month and day of month. Year zero, a month outside 1..12, a
// day of zero or past the month's end, or a day number of zero or past the
// year's end set rsp_error with all result fields zero. One item is in work at
// a time; the month walk is one table entry per cycle in the add/subtract loop
// step. The result sits in an output register, so the next item is taken while
// it waits.
module calendar_date_day_of_year_convert
   import cddoy_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic [YEAR_W-1:0]  req_year,
   input  logic [MONTH_W-1:0] req_month,
   input  logic [MDAY_W-1:0]  req_day_of_month,
   input  logic [YDAY_W-1:0]  req_day_in_year,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_error,
   output logic [YDAY_W-1:0]  rsp_year_day_out,
   output logic [MONTH_W-1:0] rsp_month_out,
   output logic [MDO_W-1:0]   rsp_month_day_out
);

   ctrl_type   ctrl;
   status_type status;

   cddoy_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   cddoy_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .status            (status),
      .req_func          (req_func),
      .req_year          (req_year),
      .req_month         (req_month),
      .req_day_of_month  (req_day_of_month),
      .req_day_in_year   (req_day_in_year),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_error         (rsp_error),
      .rsp_year_day_out  (rsp_year_day_out),
      .rsp_month_out     (rsp_month_out),
      .rsp_month_day_out (rsp_month_day_out)
   );

endmodule

@@ rtl/cddoy_seq.sv @@
module cddoy_seq
   import cddoy_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output ctrl_type   ctrl
);

   logic           busy_ff, busy_in;
   pc_type         pc_ff, pc_in;
   ucode_word_type word;
   logic           cond_true;

   assign word      = ucode_rom(pc_ff);
   assign req_ready = !busy_ff;

   always_comb begin
      case (word.cond)
         COND_ALWAYS:   cond_true = 1'b1;
         COND_INV:      cond_true = status.func_inv;
         COND_FWD_MORE: cond_true = status.fwd_more;
         COND_INV_MORE: cond_true = status.inv_more;
         COND_OUT_FREE: cond_true = status.out_free;
         default:       cond_true = 1'b1;
      endcase
   end

   always_comb begin
      ctrl.start = req_valid && !busy_ff;
      ctrl.op    = busy_ff ? word.op : OP_NOP;
      busy_in    = busy_ff;
      pc_in      = pc_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         pc_in   = PC_INIT;
      end else if (busy_ff) begin
         pc_in = cond_true ? word.t_pc : word.f_pc;
         // the finish step retires the item once the output register takes it
         if (word.op == OP_DONE && cond_true) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= PC_INIT;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

endmodule

@@ rtl/cddoy_dp.sv @@
module cddoy_dp
   import cddoy_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  ctrl_type           ctrl,
   output status_type         status,
   input  logic               req_func,
   input  logic [YEAR_W-1:0]  req_year,
   input  logic [MONTH_W-1:0] req_month,
   input  logic [MDAY_W-1:0]  req_day_of_month,
   input  logic [YDAY_W-1:0]  req_day_in_year,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_error,
   output logic [YDAY_W-1:0]  rsp_year_day_out,
   output logic [MONTH_W-1:0] rsp_month_out,
   output logic [MDO_W-1:0]   rsp_month_day_out
);

   logic               func_ff;
   logic [YEAR_W-1:0]  year_ff;
   logic [MONTH_W-1:0] month_ff;
   logic [MDAY_W-1:0]  mday_ff;
   logic [YDAY_W-1:0]  yday_ff;

   logic               leap_ff, leap_in;
   logic               err_ff, err_in;
   logic [YDAY_W-1:0]  acc_ff, acc_in;
   logic [MONTH_W-1:0] idx_ff, idx_in;

   logic               out_valid_ff, out_valid_in;
   logic               out_err_ff, out_err_in;
   logic [YDAY_W-1:0]  out_yd_ff, out_yd_in;
   logic [MONTH_W-1:0] out_m_ff, out_m_in;
   logic [MDO_W-1:0]   out_md_ff, out_md_in;

   logic [MDO_W-1:0]   len_idx;
   logic [MDO_W-1:0]   len_month;
   logic [YDAY_W-1:0]  year_limit;
   logic               out_free;

   assign len_idx    = month_len(leap_ff, idx_ff);
   assign len_month  = month_len(leap_ff, month_ff);
   assign year_limit = leap_ff ? DAYS_LEAP : DAYS_COMMON;
   assign out_free   = !out_valid_ff || rsp_ready;

   assign status.func_inv = func_ff;
   assign status.fwd_more = !err_ff && (idx_ff < month_ff);
   assign status.inv_more = !err_ff && (idx_ff < MONTHS) &&
                            (acc_ff > {{(YDAY_W-MDO_W){1'b0}}, len_idx});
   assign status.out_free = out_free;

   always_comb begin
      leap_in      = leap_ff;
      err_in       = err_ff;
      acc_in       = acc_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_err_in   = out_err_ff;
      out_yd_in    = out_yd_ff;
      out_m_in     = out_m_ff;
      out_md_in    = out_md_ff;
      case (ctrl.op)
         OP_INIT: begin
            leap_in = is_leap(year_ff);
            err_in  = 1'b0;
            idx_in  = 4'd1;
         end
         OP_CHK_FWD: begin
            // month range is checked before its length is trusted
            err_in = (year_ff == '0) || (month_ff == '0) || (month_ff > MONTHS) ||
                     (mday_ff == '0) || (mday_ff > {1'b0, len_month});
            acc_in = {{(YDAY_W-MDAY_W){1'b0}}, mday_ff};
         end
         OP_ADD: begin
            if (status.fwd_more) begin
               acc_in = acc_ff + {{(YDAY_W-MDO_W){1'b0}}, len_idx};
               idx_in = idx_ff + 4'd1;
            end
         end
         OP_CHK_INV: begin
            err_in = (year_ff == '0) || (yday_ff == '0) || (yday_ff > year_limit);
            acc_in = yday_ff;
         end
         OP_SUB: begin
            if (status.inv_more) begin
               acc_in = acc_ff - {{(YDAY_W-MDO_W){1'b0}}, len_idx};
               idx_in = idx_ff + 4'd1;
            end
         end
         OP_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_err_in   = err_ff;
               out_yd_in    = '0;
               out_m_in     = '0;
               out_md_in    = '0;
               if (!err_ff) begin
                  if (func_ff) begin
                     out_m_in  = idx_ff;
                     out_md_in = acc_ff[MDO_W-1:0];
                  end else begin
                     out_yd_in = acc_ff;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         func_ff  <= req_func;
         year_ff  <= req_year;
         month_ff <= req_month;
         mday_ff  <= req_day_of_month;
         yday_ff  <= req_day_in_year;
      end
      leap_ff    <= leap_in;
      err_ff     <= err_in;
      acc_ff     <= acc_in;
      idx_ff     <= idx_in;
      out_err_ff <= out_err_in;
      out_yd_ff  <= out_yd_in;
      out_m_ff   <= out_m_in;
      out_md_ff  <= out_md_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_error         = out_err_ff;
   assign rsp_year_day_out  = out_yd_ff;
   assign rsp_month_out     = out_m_ff;
   assign rsp_month_day_out = out_md_ff;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import cddoy_pkg::*;

   localparam logic FUNC_TO_YDAY = 1'b0;
   localparam logic FUNC_TO_DATE = 1'b1;
   localparam int   CYCLE_LIMIT  = 1_000_000;
   localparam int   HOLD_CYCLES  = 300;
   localparam int   DRAIN_CYCLES = 40;

   typedef struct packed {
      logic               err;
      logic [YDAY_W-1:0]  yday;
      logic [MONTH_W-1:0] mon;
      logic [MDO_W-1:0]   mday;
   } cal_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_func = 1'b0;
   logic [YEAR_W-1:0]  req_year = '0;
   logic [MONTH_W-1:0] req_month = '0;
   logic [MDAY_W-1:0]  req_day_of_month = '0;
   logic [YDAY_W-1:0]  req_day_in_year = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_error;
   logic [YDAY_W-1:0]  rsp_year_day_out;
   logic [MONTH_W-1:0] rsp_month_out;
   logic [MDO_W-1:0]   rsp_month_day_out;

   cal_result_type pending_results[$];
   cal_result_type want;
   bit          idle_en = 1'b0;
   bit          long_hold_req = 1'b0;
   int          stall_left = 0;
   int          cycle_count = 0;
   int          fail_count = 0;
   int          n_items = 0;
   int          n_fwd = 0;
   int          n_inv = 0;
   int          n_err = 0;
   int          n_leap = 0;
   int          n_results = 0;

   calendar_date_day_of_year_convert dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_func          (req_func),
      .req_year          (req_year),
      .req_month         (req_month),
      .req_day_of_month  (req_day_of_month),
      .req_day_in_year   (req_day_in_year),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_error         (rsp_error),
      .rsp_year_day_out  (rsp_year_day_out),
      .rsp_month_out     (rsp_month_out),
      .rsp_month_day_out (rsp_month_day_out)
   );

   always #1 clock = ~clock;

   function automatic bit leap_year(input logic [YEAR_W-1:0] y);
      int yi;
      yi = int'(y);
      return ((yi % 4 == 0) && (yi % 100 != 0)) || (yi % 400 == 0);
   endfunction

   function automatic int month_length_days(input bit leap, input int m);
      case (m)
         1, 3, 5, 7, 8, 10, 12: return 31;
         4, 6, 9, 11:           return 30;
         2:                     return leap ? 29 : 28;
         default:               return 0;
      endcase
   endfunction

   function automatic cal_result_type convert_calendar(input logic f,
                                                    input logic [YEAR_W-1:0]  y,
                                                    input logic [MONTH_W-1:0] m,
                                                    input logic [MDAY_W-1:0]  md,
                                                    input logic [YDAY_W-1:0]  yd);
      cal_result_type r;
      bit          leap;
      int          sum;
      int          rem;
      int          mi;
      r    = '0;
      leap = leap_year(y);
      if (f == FUNC_TO_YDAY) begin
         // month range checked before any length lookup
         if (y == 0 || m == 0 || m > 12 || md == 0)
            r.err = 1'b1;
         else if (md > month_length_days(leap, int'(m)))
            r.err = 1'b1;
         else begin
            sum = int'(md);
            for (mi = 1; mi < m; mi++)
               sum += month_length_days(leap, mi);
            r.yday = YDAY_W'(sum);
         end
      end else begin
         if (y == 0 || yd == 0 || yd > (leap ? 366 : 365))
            r.err = 1'b1;
         else begin
            rem = int'(yd);
            mi  = 1;
            while (mi < 12 && rem > month_length_days(leap, mi)) begin
               rem -= month_length_days(leap, mi);
               mi++;
            end
            r.mon  = MONTH_W'(mi);
            r.mday = MDO_W'(rem);
         end
      end
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [YEAR_W-1:0] pick_year();
      case ($urandom_range(0, 4))
         0:       return YEAR_W'($urandom_range(1, 65535));
         1:       return YEAR_W'($urandom_range(1, 163) * 400);
         2:       return YEAR_W'($urandom_range(1, 655) * 100);
         3:       return YEAR_W'($urandom_range(1, 16383) * 4);
         default: return YEAR_W'($urandom_range(1, 3000));
      endcase
   endfunction

   task automatic send_item(input logic f, input logic [YEAR_W-1:0] y,
                            input logic [MONTH_W-1:0] m, input logic [MDAY_W-1:0] md,
                            input logic [YDAY_W-1:0] yd);
      int          gap;
      cal_result_type r;
      gap = (idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_func         = f;
      req_year         = y;
      req_month        = m;
      req_day_of_month = md;
      req_day_in_year  = yd;
      do @(posedge clock); while (!req_ready);
      r = convert_calendar(f, y, m, md, yd);
      pending_results.push_back(r);
      n_items++;
      if (f == FUNC_TO_YDAY) n_fwd++; else n_inv++;
      if (r.err) n_err++;
      if (leap_year(y)) n_leap++;
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic send_random_item();
      logic               f;
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [MDAY_W-1:0]  md;
      logic [YDAY_W-1:0]  yd;
      int                 len;
      int                 lim;
      f  = 1'($urandom_range(0, 1));
      y  = YEAR_W'($urandom_range(0, 65535));
      m  = MONTH_W'($urandom_range(0, 15));
      md = MDAY_W'($urandom_range(0, 63));
      yd = YDAY_W'($urandom_range(0, 511));
      // most items are well-formed dates, the rest raw noise
      if ($urandom_range(0, 99) < 80) begin
         y = pick_year();
         if (f == FUNC_TO_YDAY) begin
            m   = MONTH_W'($urandom_range(1, 12));
            len = month_length_days(leap_year(y), int'(m));
            case ($urandom_range(0, 9))
               0:       md = MDAY_W'(len + 1);
               1:       md = MDAY_W'(len);
               default: md = MDAY_W'($urandom_range(1, len));
            endcase
         end else begin
            lim = leap_year(y) ? 366 : 365;
            case ($urandom_range(0, 19))
               0:       yd = YDAY_W'(lim + 1);
               1:       yd = YDAY_W'(lim);
               2:       yd = '0;
               default: yd = YDAY_W'($urandom_range(1, lim));
            endcase
         end
      end
      send_item(f, y, m, md, yd);
   endtask

   task automatic test_forward_limits();
      send_item(FUNC_TO_YDAY, 16'd2001,  4'd1,  6'd1,  9'd0);
      send_item(FUNC_TO_YDAY, 16'd2001,  4'd12, 6'd31, 9'd511);
      send_item(FUNC_TO_YDAY, 16'd2000,  4'd12, 6'd31, 9'd0);
      send_item(FUNC_TO_YDAY, 16'd2024,  4'd2,  6'd29, 9'd100);
      send_item(FUNC_TO_YDAY, 16'd2100,  4'd3,  6'd1,  9'd0);
      send_item(FUNC_TO_YDAY, 16'd2000,  4'd2,  6'd29, 9'd0);
      send_item(FUNC_TO_YDAY, 16'd65535, 4'd12, 6'd31, 9'd0);
      send_item(FUNC_TO_YDAY, 16'd1,     4'd1,  6'd1,  9'd0);
      stop_sending();
   endtask

   task automatic test_forward_errors();
      send_item(FUNC_TO_YDAY, 16'd0,    4'd5,  6'd10, 9'd0);
      send_item(FUNC_TO_YDAY, 16'd1999, 4'd0,  6'd10, 9'd0);
      send_item(FUNC_TO_YDAY, 16'd1999, 4'd13, 6'd10, 9'd0);
      send_item(FUNC_TO_YDAY, 16'd1999, 4'd15, 6'd63, 9'd511);
      send_item(FUNC_TO_YDAY, 16'd1999, 4'd7,  6'd0,  9'd0);
      send_item(FUNC_TO_YDAY, 16'd1999, 4'd7,  6'd63, 9'd0);
      send_item(FUNC_TO_YDAY, 16'd1900, 4'd2,  6'd29, 9'd0);
      send_item(FUNC_TO_YDAY, 16'd2023, 4'd4,  6'd31, 9'd0);
      stop_sending();
   endtask

   task automatic test_inverse_cases();
      send_item(FUNC_TO_DATE, 16'd2001,  4'd0, 6'd0,  9'd1);
      send_item(FUNC_TO_DATE, 16'd2001,  4'd0, 6'd0,  9'd365);
      send_item(FUNC_TO_DATE, 16'd2000,  4'd15, 6'd63, 9'd366);
      send_item(FUNC_TO_DATE, 16'd2024,  4'd0, 6'd0,  9'd60);
      send_item(FUNC_TO_DATE, 16'd2023,  4'd0, 6'd0,  9'd60);
      send_item(FUNC_TO_DATE, 16'd65535, 4'd0, 6'd0,  9'd511);
      send_item(FUNC_TO_DATE, 16'd1900,  4'd0, 6'd0,  9'd366);
      send_item(FUNC_TO_DATE, 16'd2400,  4'd0, 6'd0,  9'd0);
      send_item(FUNC_TO_DATE, 16'd0,     4'd0, 6'd0,  9'd100);
      stop_sending();
   endtask

   task automatic test_random_with_gaps(input int count);
      idle_en = 1'b1;
      repeat (count) send_random_item();
      stop_sending();
   endtask

   task automatic test_random_back_to_back(input int count);
      idle_en = 1'b0;
      repeat (count) send_random_item();
      stop_sending();
   endtask

   task automatic test_output_hold_off();
      idle_en       = 1'b0;
      long_hold_req = 1'b1;
      repeat (12) send_random_item();
      stop_sending();
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_ready     = 1'b0;
            long_hold_req = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_ready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if (idle_en && $urandom_range(0, 99) < 25)
               stall_left = pick_gap();
         end
      end
   end

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (pending_results.size() == 0) begin
            $display("%0t: result with no item outstanding, expected none, %s",
                     $time, "actual");
            $display("   err=%0d yday=%0d mon=%0d mday=%0d",
                     rsp_error, rsp_year_day_out, rsp_month_out, rsp_month_day_out);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("error",         int'(want.err),  int'(rsp_error));
            check_field("year_day_out",  int'(want.yday), int'(rsp_year_day_out));
            check_field("month_out",     int'(want.mon),  int'(rsp_month_out));
            check_field("month_day_out", int'(want.mday), int'(rsp_month_day_out));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d items outstanding",
               cycle_count, pending_results.size());
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_forward_limits();
      test_forward_errors();
      test_inverse_cases();
      test_random_with_gaps(700);
      test_output_hold_off();
      test_random_back_to_back(300);
      test_random_with_gaps(500);

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d items (%0d date to day, %0d day to date), %0d invalid, %0d in leap years",
               n_items, n_fwd, n_inv, n_err, n_leap);
      $display("%0d results checked, %0d mismatches, %0d cycles",
               n_results, fail_count, cycle_count);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/cddoy_pkg.sv
rtl/cddoy_seq.sv
rtl/cddoy_dp.sv
rtl/calendar_date_day_of_year_convert.sv
bench/tb.sv
